>>> rtl/clsq_pkg.sv
// Shared types, codes and lookup functions for the four-bit LCD sequencer.
package clsq_pkg;

  // Input kinds as they arrive on the input channel.
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_TEXT    = 3'd2;
  localparam logic [2:0] KIND_SETPOS  = 3'd3;
  localparam logic [2:0] KIND_INIT    = 3'd4;
  localparam logic [2:0] KIND_CLEAR   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SETTLE     = 3'd0;
  localparam logic [2:0] CFG_CLEAR_WAIT = 3'd1;
  localparam logic [2:0] CFG_INIT_LONG  = 3'd2;
  localparam logic [2:0] CFG_INIT_SHORT = 3'd3;
  localparam logic [2:0] CFG_COL_LIMIT  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [9:0]  SETTLE_RST     = 10'd100;
  localparam logic [12:0] CLEAR_WAIT_RST = 13'd3000;
  localparam logic [12:0] INIT_LONG_RST  = 13'd4500;
  localparam logic [9:0]  INIT_SHORT_RST = 10'd150;
  localparam logic [4:0]  COL_LIMIT_RST  = 5'd20;

  // Sequencer step codes.
  localparam logic [4:0] STEP_IDLE       = 5'd0;
  localparam logic [4:0] STEP_BYTE_HI    = 5'd1;
  localparam logic [4:0] STEP_BYTE_LO    = 5'd2;
  localparam logic [4:0] STEP_CLR_HI     = 5'd3;
  localparam logic [4:0] STEP_CLR_LO     = 5'd4;
  localparam logic [4:0] STEP_INIT_FIRST = 5'd5;
  localparam logic [4:0] STEP_INIT_LAST  = 5'd16;

  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] BYTE_SET_DDR = 8'h80;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_COMMAND,
    OP_TEXT,
    OP_SETPOS,
    OP_INIT,
    OP_CLEAR,
    OP_NOP
  } clsq_op_t;

  typedef enum logic [1:0] {
    PH_SETUP,
    PH_PULSE,
    PH_SETTLE,
    PH_EXTRA
  } clsq_phase_t;

  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_LONG,
    EXTRA_SHORT,
    EXTRA_CLEAR
  } clsq_extra_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    clsq_op_t   op;
    logic [7:0] data_byte;
    logic [4:0] col;
  } clsq_item_t;

  function automatic logic [3:0] reverse4(input logic [3:0] n);
    reverse4 = {n[0], n[1], n[2], n[3]};
  endfunction

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'd0;
      2'd1:    base = 7'd64;
      2'd2:    base = 7'd20;
      default: base = 7'd84;
    endcase
    row_base = base;
  endfunction

  // Power-up sequence: 3,3,3,2, then 28h, 0Fh, 01h, 06h as nibble pairs.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'h3;
      4'd1:    n = 4'h3;
      4'd2:    n = 4'h3;
      4'd3:    n = 4'h2;
      4'd4:    n = 4'h2;
      4'd5:    n = 4'h8;
      4'd6:    n = 4'h0;
      4'd7:    n = 4'hF;
      4'd8:    n = 4'h0;
      4'd9:    n = 4'h1;
      4'd10:   n = 4'h0;
      4'd11:   n = 4'h6;
      default: n = 4'h0;
    endcase
    init_nibble = n;
  endfunction

  function automatic logic [3:0] nibble_for_step(input logic [4:0] step,
                                                 input logic [7:0] pend);
    logic [3:0] n;
    logic [4:0] idx;
    idx = step - STEP_INIT_FIRST;
    if (step == STEP_BYTE_HI || step == STEP_CLR_HI) begin
      n = pend[7:4];
    end else if (step == STEP_BYTE_LO || step == STEP_CLR_LO) begin
      n = pend[3:0];
    end else if (step >= STEP_INIT_FIRST && step <= STEP_INIT_LAST) begin
      n = init_nibble(idx[3:0]);
    end else begin
      n = 4'h0;
    end
    nibble_for_step = n;
  endfunction

  function automatic clsq_extra_t extra_for_step(input logic [4:0] step);
    clsq_extra_t sel;
    case (step)
      STEP_CLR_LO:        sel = EXTRA_CLEAR;
      STEP_INIT_FIRST:    sel = EXTRA_LONG;
      STEP_INIT_FIRST + 5'd1: sel = EXTRA_LONG;
      STEP_INIT_FIRST + 5'd2: sel = EXTRA_SHORT;
      STEP_INIT_FIRST + 5'd9: sel = EXTRA_CLEAR;
      default:            sel = EXTRA_NONE;
    endcase
    extra_for_step = sel;
  endfunction

endpackage

>>> rtl/clsq_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
module clsq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_value,
  input  logic [1:0]         in_row,
  input  logic [4:0]         in_column,
  output logic               head_valid,
  output clsq_pkg::clsq_item_t head_item,
  input  logic               head_pop
);
  import clsq_pkg::*;

  clsq_item_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  clsq_item_t item_c;
  logic [6:0] addr_c;

  // Classify the raw kind and prepare the byte the back end will send.
  always_comb begin
    addr_c = row_base(in_row) + {2'b00, in_column};
    item_c.data_byte = in_value;
    item_c.col       = in_column;
    case (in_kind)
      KIND_TICK:    item_c.op = OP_TICK;
      KIND_COMMAND: item_c.op = OP_COMMAND;
      KIND_TEXT:    item_c.op = OP_TEXT;
      KIND_SETPOS: begin
        item_c.op        = OP_SETPOS;
        item_c.data_byte = BYTE_SET_DDR | {1'b0, addr_c};
      end
      KIND_INIT:    item_c.op = OP_INIT;
      KIND_CLEAR:   item_c.op = OP_CLEAR;
      default:      item_c.op = OP_NOP;
    endcase
  end

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != 2'd0);
  assign head_item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, head_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

>>> rtl/clsq_back.sv
// Back end: nibble sequencer, wait counter, configuration registers and result register.
module clsq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               head_valid,
  input  clsq_pkg::clsq_item_t head_item,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_register_select,
  output logic               out_enable,
  output logic [3:0]         out_data_pins,
  output logic               out_busy_res,
  output logic [1:0]         out_status
);
  import clsq_pkg::*;

  logic [9:0]  settle_r;
  logic [12:0] clear_wait_r;
  logic [12:0] init_long_r;
  logic [9:0]  init_short_r;
  logic [4:0]  col_limit_r;

  clsq_phase_t phase_r, phase_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [12:0] wait_r, wait_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        rs_r, rs_nxt;
  logic        en_r, en_nxt;
  logic [3:0]  pin_r, pin_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [1:0]  status_c;

  logic        out_valid_r;
  logic        rs_out_r, en_out_r, busy_out_r;
  logic [3:0]  pin_out_r;
  logic [1:0]  status_out_r;

  logic        take;
  logic        last_nibble;
  logic [4:0]  step_inc;
  logic [12:0] extra_c;

  assign take     = head_valid && (!out_valid_r || !out_stall);
  assign head_pop = take;
  assign step_inc = step_r + 5'd1;

  assign last_nibble = (step_r == STEP_BYTE_LO) || (step_r == STEP_CLR_LO) ||
                       (step_r >= STEP_INIT_LAST) || (step_r == STEP_IDLE);

  always_comb begin
    case (extra_for_step(step_r))
      EXTRA_LONG:  extra_c = init_long_r;
      EXTRA_SHORT: extra_c = {3'b000, init_short_r};
      EXTRA_CLEAR: extra_c = clear_wait_r;
      default:     extra_c = 13'd0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    wait_nxt  = wait_r;
    pend_nxt  = pend_r;
    rs_nxt    = rs_r;
    en_nxt    = en_r;
    pin_nxt   = pin_r;
    col_nxt   = col_r;
    status_c  = STATUS_OK;
    if (take) begin
      case (head_item.op)
        OP_TICK: begin
          if (step_r != STEP_IDLE) begin
            case (phase_r)
              PH_SETUP: begin
                en_nxt    = 1'b1;
                phase_nxt = PH_PULSE;
              end
              PH_PULSE: begin
                en_nxt    = 1'b0;
                phase_nxt = PH_SETTLE;
                wait_nxt  = {3'b000, settle_r};
              end
              default: begin
                if (wait_r > 13'd1) begin
                  wait_nxt = wait_r - 13'd1;
                end else if (phase_r == PH_SETTLE && extra_c != 13'd0) begin
                  phase_nxt = PH_EXTRA;
                  wait_nxt  = extra_c;
                end else if (last_nibble) begin
                  step_nxt  = STEP_IDLE;
                  phase_nxt = PH_SETUP;
                  wait_nxt  = 13'd0;
                  en_nxt    = 1'b0;
                end else begin
                  step_nxt  = step_inc;
                  pin_nxt   = reverse4(nibble_for_step(step_inc, pend_r));
                  en_nxt    = 1'b0;
                  phase_nxt = PH_SETUP;
                end
              end
            endcase
          end
        end
        OP_COMMAND, OP_TEXT, OP_SETPOS, OP_INIT, OP_CLEAR: begin
          if (step_r != STEP_IDLE) begin
            status_c = STATUS_REJECTED;
          end else if (head_item.op == OP_TEXT && col_r >= col_limit_r) begin
            status_c = STATUS_DROPPED;
          end else begin
            case (head_item.op)
              OP_INIT: begin
                step_nxt = STEP_INIT_FIRST;
                pend_nxt = 8'h00;
              end
              OP_CLEAR: begin
                step_nxt = STEP_CLR_HI;
                pend_nxt = BYTE_CLEAR;
              end
              default: begin
                step_nxt = STEP_BYTE_HI;
                pend_nxt = head_item.data_byte;
              end
            endcase
            rs_nxt    = (head_item.op == OP_TEXT);
            wait_nxt  = 13'd0;
            en_nxt    = 1'b0;
            phase_nxt = PH_SETUP;
            pin_nxt   = reverse4(nibble_for_step(step_nxt, pend_nxt));
            if (head_item.op == OP_TEXT) begin
              col_nxt = col_r + 5'd1;
            end else if (head_item.op == OP_SETPOS) begin
              col_nxt = head_item.col;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETUP;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      wait_r      <= 13'd0;
      pend_r      <= 8'h00;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      pin_r       <= 4'h0;
      col_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      wait_r      <= wait_nxt;
      pend_r      <= pend_nxt;
      rs_r        <= rs_nxt;
      en_r        <= en_nxt;
      pin_r       <= pin_nxt;
      col_r       <= col_nxt;
      out_valid_r <= take || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rs_out_r     <= rs_nxt;
      en_out_r     <= en_nxt;
      pin_out_r    <= pin_nxt;
      busy_out_r   <= (step_nxt != STEP_IDLE);
      status_out_r <= status_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r     <= SETTLE_RST;
      clear_wait_r <= CLEAR_WAIT_RST;
      init_long_r  <= INIT_LONG_RST;
      init_short_r <= INIT_SHORT_RST;
      col_limit_r  <= COL_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SETTLE:     settle_r     <= cfg_data[9:0];
        CFG_CLEAR_WAIT: clear_wait_r <= cfg_data;
        CFG_INIT_LONG:  init_long_r  <= cfg_data;
        CFG_INIT_SHORT: init_short_r <= cfg_data[9:0];
        CFG_COL_LIMIT:  col_limit_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = rs_out_r;
  assign out_enable          = en_out_r;
  assign out_data_pins       = pin_out_r;
  assign out_busy_res        = busy_out_r;
  assign out_status          = status_out_r;

endmodule

>>> rtl/char_lcd_four_bit_sequencer.sv
// Top level of the four-bit character LCD sequencer.
//
// The block drives an HD44780-style 20x4 display over a four-bit bus.
// Each input item is a one-microsecond tick (kind 0), an unused kind (6, 7)
// or a request: a command byte, a text byte, set position, init or clear.
// Every input item yields exactly one result item that carries the RS, E
// and data pin levels after that item, a busy flag and a status code (ok,
// rejected because busy, or text dropped because the row is full).
// Input and result channels use valid and stall; an item moves at an edge
// where valid is high and stall is low. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready and should be
// written only while no item is in flight.
// Throughput is one item per clock cycle while the receiver does not stall.
// A two-entry queue sits between the classifying front end and the back
// end that runs the sequencer and finishes one item per unstalled cycle.
// An accepted item is written into the queue; its result is registered when
// the back end takes it. When the receiver stalls, the result register holds
// and the queue fills; in_stall rises once both queue entries are taken.
// Synchronous active-low reset empties the queue, drops any pending result,
// puts the sequencer in its idle step and reloads the register defaults.
module char_lcd_four_bit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_value,
  input  logic [1:0]  in_row,
  input  logic [4:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_register_select,
  output logic        out_enable,
  output logic [3:0]  out_data_pins,
  output logic        out_busy_res,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import clsq_pkg::*;

  logic       head_valid;
  logic       head_pop;
  clsq_item_t head_item;

  // Registers take every write at once.
  assign cfg_ready = 1'b1;

  clsq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .in_row     (in_row),
    .in_column  (in_column),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  clsq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .head_pop            (head_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_enable          (out_enable),
    .out_data_pins       (out_data_pins),
    .out_busy_res        (out_busy_res),
    .out_status          (out_status)
  );

endmodule

>>> sim/clsq_checker.sv
// Checker for the four-bit LCD sequencer: mirrors the pin sequencer and checks each result item.
`timescale 1ns / 100ps

module clsq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_value,
  input  logic [1:0]  in_row,
  input  logic [4:0]  in_column,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_register_select,
  input  logic        out_enable,
  input  logic [3:0]  out_data_pins,
  input  logic        out_busy_res,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          pending_results,
  output int          fail_count
);
  import clsq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       rs;
    logic       e;
    logic [3:0] pins;
    logic       busy;
    logic [1:0] status;
  } pin_levels_t;

  // Pin levels still owed by the block, oldest first.
  pin_levels_t pin_forecast_q[$];
  int          results_seen;

  // Shadow registers.
  logic [9:0]  settle_reg;
  logic [12:0] clear_wait_reg;
  logic [12:0] init_long_reg;
  logic [9:0]  init_short_reg;
  logic [4:0]  col_limit_reg;

  // Shadow sequencer state.
  logic [4:0]  step_q;
  clsq_phase_t phase_q;
  logic [12:0] wait_left;
  logic [7:0]  byte_q;
  logic        rs_lvl;
  logic        e_lvl;
  logic [3:0]  db_pins;
  logic [4:0]  cursor_col;

  // Power-up nibbles: 3, 3, 3, 2, then 28h, 0Fh, 01h and 06h split in halves.
  function automatic logic [3:0] power_up_nibble(input logic [4:0] step);
    logic [4:0] pos;
    logic [3:0] nib;
    pos = step - STEP_INIT_FIRST;
    case (pos)
      5'd0, 5'd1, 5'd2: nib = 4'h3;
      5'd3, 5'd4:       nib = 4'h2;
      5'd5:             nib = 4'h8;
      5'd7:             nib = 4'hF;
      5'd9:             nib = 4'h1;
      5'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  // Puts the nibble of the current step on the pins with E low.
  function automatic void present_nibble();
    logic [3:0] nib;
    nib = 4'h0;
    if (step_q == STEP_BYTE_HI || step_q == STEP_CLR_HI) begin
      nib = byte_q[7:4];
    end else if (step_q == STEP_BYTE_LO || step_q == STEP_CLR_LO) begin
      nib = byte_q[3:0];
    end else if (step_q >= STEP_INIT_FIRST && step_q <= STEP_INIT_LAST) begin
      nib = power_up_nibble(step_q);
    end
    // DB7 carries nibble bit 0, DB4 carries nibble bit 3.
    db_pins = {nib[0], nib[1], nib[2], nib[3]};
    e_lvl   = 1'b0;
    phase_q = PH_SETUP;
  endfunction

  // Extra wait that follows the settle time of the current step.
  function automatic logic [12:0] trailing_wait();
    logic [4:0] pos;
    pos = step_q - STEP_INIT_FIRST;
    if (step_q == STEP_CLR_LO) return clear_wait_reg;
    if (step_q >= STEP_INIT_FIRST && step_q <= STEP_INIT_LAST) begin
      if (pos == 5'd0 || pos == 5'd1) return init_long_reg;
      if (pos == 5'd2) return {3'b000, init_short_reg};
      if (pos == 5'd9) return clear_wait_reg;
    end
    return 13'd0;
  endfunction

  function automatic void finish_nibble();
    if (step_q == STEP_BYTE_LO || step_q == STEP_CLR_LO || step_q >= STEP_INIT_LAST ||
        step_q == STEP_IDLE) begin
      step_q    = STEP_IDLE;
      phase_q   = PH_SETUP;
      wait_left = 13'd0;
      e_lvl     = 1'b0;
    end else begin
      step_q = step_q + 5'd1;
      present_nibble();
    end
  endfunction

  function automatic void microsecond_tick();
    logic [12:0] extra;
    if (step_q == STEP_IDLE) return;
    case (phase_q)
      PH_SETUP: begin
        e_lvl   = 1'b1;
        phase_q = PH_PULSE;
      end
      PH_PULSE: begin
        e_lvl     = 1'b0;
        phase_q   = PH_SETTLE;
        wait_left = {3'b000, settle_reg};
      end
      PH_SETTLE: begin
        // A settle time of zero ends on the first tick, like a settle time of one.
        if (wait_left > 13'd1) begin
          wait_left = wait_left - 13'd1;
        end else begin
          extra = trailing_wait();
          if (extra != 13'd0) begin
            phase_q   = PH_EXTRA;
            wait_left = extra;
          end else begin
            finish_nibble();
          end
        end
      end
      default: begin
        if (wait_left > 13'd1) begin
          wait_left = wait_left - 13'd1;
        end else begin
          finish_nibble();
        end
      end
    endcase
  endfunction

  function automatic void launch(input logic [4:0] first_step, input logic [7:0] b,
                                 input logic rs);
    step_q    = first_step;
    byte_q    = b;
    rs_lvl    = rs;
    wait_left = 13'd0;
    present_nibble();
  endfunction

  // Applies one input item to the shadow state and returns the pin levels after it.
  function automatic pin_levels_t next_pin_levels(input logic [2:0] kind,
                                                  input logic [7:0] value,
                                                  input logic [1:0] row,
                                                  input logic [4:0] column);
    pin_levels_t r;
    logic [1:0]  st;
    logic [6:0]  addr;
    st = STATUS_OK;
    case (row)
      2'd0:    addr = 7'd0;
      2'd1:    addr = 7'd64;
      2'd2:    addr = 7'd20;
      default: addr = 7'd84;
    endcase
    addr = addr + {2'b00, column};
    if (kind == KIND_TICK) begin
      microsecond_tick();
    end else if (kind <= KIND_CLEAR) begin
      if (step_q != STEP_IDLE) begin
        st = STATUS_REJECTED;
      end else begin
        case (kind)
          KIND_COMMAND: launch(STEP_BYTE_HI, value, 1'b0);
          KIND_TEXT: begin
            if (cursor_col >= col_limit_reg) begin
              st = STATUS_DROPPED;
            end else begin
              launch(STEP_BYTE_HI, value, 1'b1);
              cursor_col = cursor_col + 5'd1;
            end
          end
          KIND_SETPOS: begin
            launch(STEP_BYTE_HI, BYTE_SET_DDR | {1'b0, addr}, 1'b0);
            cursor_col = column;
          end
          KIND_INIT: launch(STEP_INIT_FIRST, 8'h00, 1'b0);
          default:   launch(STEP_CLR_HI, BYTE_CLEAR, 1'b0);
        endcase
      end
    end
    r.rs     = rs_lvl;
    r.e      = e_lvl;
    r.pins   = db_pins;
    r.busy   = (step_q != STEP_IDLE);
    r.status = st;
    return r;
  endfunction

  function automatic void log_failure(input string why, input pin_levels_t want,
                                      input pin_levels_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: result %0d %s: expected rs=%0b e=%0b db=%h busy=%0b status=%0d",
               $time, results_seen, why, want.rs, want.e, want.pins, want.busy,
               want.status);
      $display("%0t: result %0d %s: got      rs=%0b e=%0b db=%h busy=%0b status=%0d",
               $time, results_seen, why, got.rs, got.e, got.pins, got.busy, got.status);
    end
  endfunction

  always @(posedge clk) begin : watch
    pin_levels_t got;
    pin_levels_t want;
    if (!rst_n) begin
      pin_forecast_q.delete();
      settle_reg     = SETTLE_RST;
      clear_wait_reg = CLEAR_WAIT_RST;
      init_long_reg  = INIT_LONG_RST;
      init_short_reg = INIT_SHORT_RST;
      col_limit_reg  = COL_LIMIT_RST;
      step_q         = STEP_IDLE;
      phase_q        = PH_SETUP;
      wait_left      = 13'd0;
      byte_q         = 8'h00;
      rs_lvl         = 1'b0;
      e_lvl          = 1'b0;
      db_pins        = 4'h0;
      cursor_col     = 5'd0;
    end else begin
      // Results leave before the item taken at this edge can produce one.
      if (out_valid && !out_stall) begin
        got.rs     = out_register_select;
        got.e      = out_enable;
        got.pins   = out_data_pins;
        got.busy   = out_busy_res;
        got.status = out_status;
        if (pin_forecast_q.size() == 0) begin
          log_failure("arrived with no item waiting", '0, got);
        end else begin
          want = pin_forecast_q.pop_front();
          if (got.rs !== want.rs || got.e !== want.e || got.pins !== want.pins ||
              got.busy !== want.busy || got.status !== want.status) begin
            log_failure("mismatch", want, got);
          end
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SETTLE:     settle_reg     = cfg_data[9:0];
          CFG_CLEAR_WAIT: clear_wait_reg = cfg_data;
          CFG_INIT_LONG:  init_long_reg  = cfg_data;
          CFG_INIT_SHORT: init_short_reg = cfg_data[9:0];
          CFG_COL_LIMIT:  col_limit_reg  = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pin_forecast_q.push_back(next_pin_levels(in_kind, in_value, in_row, in_column));
      end
    end
    pending_results = pin_forecast_q.size();
  end

endmodule

>>> sim/tb_char_lcd_four_bit_sequencer.sv
// Testbench top for the four-bit LCD sequencer: drives items and register writes, gives the verdict.
`timescale 1ns / 100ps

module tb_char_lcd_four_bit_sequencer;
  import clsq_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 480;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 3_000_000;

  // Kinds six and seven are not requests; the block ignores them.
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  // A register index past the last register; writes to it are ignored.
  localparam logic [2:0] CFG_UNUSED   = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = KIND_TICK;
  logic [7:0]  in_value = 8'h00;
  logic [1:0]  in_row = 2'd0;
  logic [4:0]  in_column = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_register_select;
  logic        out_enable;
  logic [3:0]  out_data_pins;
  logic        out_busy_res;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SETTLE;
  logic [12:0] cfg_data = 13'd0;

  int pending_results;
  int fail_count;

  // The timing the block runs with, kept here so that each request can be
  // followed by exactly the ticks it needs to finish.
  int cur_settle = int'(SETTLE_RST);
  int cur_clear  = int'(CLEAR_WAIT_RST);
  int cur_long   = int'(INIT_LONG_RST);
  int cur_short  = int'(INIT_SHORT_RST);

  int           sent_items = 0;
  int           burst_left = 0;
  int           cycle_count = 0;
  stall_style_t stall_style = STALL_NONE;
  int           stall_left = 0;

  always #HALF_PERIOD clk = ~clk;

  char_lcd_four_bit_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_value            (in_value),
    .in_row              (in_row),
    .in_column           (in_column),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_enable          (out_enable),
    .out_data_pins       (out_data_pins),
    .out_busy_res        (out_busy_res),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  clsq_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_value            (in_value),
    .in_row              (in_row),
    .in_column           (in_column),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_enable          (out_enable),
    .out_data_pins       (out_data_pins),
    .out_busy_res        (out_busy_res),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pending_results     (pending_results),
    .fail_count          (fail_count)
  );

  // The receiver picks a stall style for a stretch of cycles, then another.
  // The styles are no stall, random stalls of two densities and a periodic
  // pattern, so result backpressure lands on every part of a nibble's timing.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 1) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = ((stall_left % 8) < 3);
    endcase
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_char_lcd_four_bit_sequencer: done, errors");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after it was taken. The
  // sender works in bursts; between bursts valid drops for a few cycles. Inside
  // a burst valid stays high and the next call simply replaces the payload.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] value,
                           input logic [1:0] row, input logic [4:0] column);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid  = 1'b1;
    in_kind   = kind;
    in_value  = value;
    in_row    = row;
    in_column = column;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (kind != KIND_SPARE_A && kind != KIND_SPARE_B) sent_items++;
  endtask

  // Ticks ignore their payload fields, so those carry random bits.
  task automatic run_ticks(input int count);
    repeat (count) send_item(KIND_TICK, 8'($urandom), 2'($urandom), 5'($urandom));
  endtask

  // Number of ticks from the acceptance of a request to the return to idle:
  // each nibble takes one tick to raise E, one to lower it and the settle
  // time (at least one tick), plus the extra waits of clear and init.
  function automatic int run_length(input logic [2:0] kind);
    int nib;
    nib = 2 + ((cur_settle == 0) ? 1 : cur_settle);
    case (kind)
      KIND_INIT:  return 12 * nib + 2 * cur_long + cur_short + cur_clear;
      KIND_CLEAR: return 2 * nib + cur_clear;
      default:    return 2 * nib;
    endcase
  endfunction

  // A request followed by just enough ticks to see it through.
  task automatic issue(input logic [2:0] kind, input logic [7:0] value,
                       input logic [1:0] row, input logic [4:0] column);
    send_item(kind, value, row, column);
    run_ticks(run_length(kind));
  endtask

  // Stops offering items and waits until every result item has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [12:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_timing(input int settle, input int clear_wait, input int init_long,
                                input int init_short, input int col_limit);
    write_reg(CFG_SETTLE, 13'(settle));
    write_reg(CFG_CLEAR_WAIT, 13'(clear_wait));
    write_reg(CFG_INIT_LONG, 13'(init_long));
    write_reg(CFG_INIT_SHORT, 13'(init_short));
    write_reg(CFG_COL_LIMIT, 13'(col_limit));
    cur_settle = settle & 'h3FF;
    cur_clear  = clear_wait & 'h1FFF;
    cur_long   = init_long & 'h1FFF;
    cur_short  = init_short & 'h3FF;
  endtask

  // Mostly columns inside the 20-column row, sometimes anything the field holds.
  task automatic send_random_request(input logic [2:0] kind);
    send_item(kind, 8'($urandom), 2'($urandom),
              ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 19)));
  endtask

  // One random sequence. Most are well formed: a request and the ticks that
  // finish it, sometimes with a few idle ticks after. The rest are broken:
  // a second request cuts in and is mostly turned away, an unused kind slips in
  // first, or the ticks may stop early so the next request finds the block busy.
  task automatic random_sequence();
    logic [2:0] kind;
    int         pick;
    int         len;
    int         cut;
    pick = $urandom_range(0, 99);
    kind = (pick < 35) ? KIND_TEXT :
           (pick < 55) ? KIND_COMMAND :
           (pick < 75) ? KIND_SETPOS :
           (pick < 88) ? KIND_CLEAR : KIND_INIT;
    len = run_length(kind);
    cut = $urandom_range(0, len);
    case ($urandom_range(0, 9))
      7: begin
        send_random_request(kind);
        run_ticks(cut);
        send_random_request(3'($urandom_range(KIND_COMMAND, KIND_CLEAR)));
        run_ticks(len - cut);
      end
      8: begin
        send_item(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B,
                  8'($urandom), 2'($urandom), 5'($urandom));
        send_random_request(kind);
        run_ticks(len);
      end
      9: begin
        send_random_request(kind);
        run_ticks(cut);
      end
      default: begin
        send_random_request(kind);
        run_ticks(len + $urandom_range(0, 2));
      end
    endcase
  endtask

  // Random timing: short settle and waits keep sequences brief so that many
  // complete; the column limit is often tiny so that dropped text shows up.
  task automatic random_timing();
    program_timing(($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3),
                   $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 4),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 31));
  endtask

  initial begin
    int rand_goal;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Register defaults: a command runs with the power-up settle time.
    issue(KIND_COMMAND, 8'hA5, 2'd0, 5'd0);

    // Fast timing and a two-column row for the directed cases.
    drain_results();
    program_timing(1, 2, 3, 1, 2);
    // A tick and an unused kind while idle change nothing.
    send_item(KIND_TICK, 8'hFF, 2'd3, 5'd31);
    send_item(KIND_SPARE_A, 8'hFF, 2'd3, 5'd31);
    issue(KIND_INIT, 8'h00, 2'd0, 5'd0);
    issue(KIND_COMMAND, 8'h00, 2'd0, 5'd0);
    issue(KIND_COMMAND, 8'hFF, 2'd0, 5'd0);
    issue(KIND_SETPOS, 8'h00, 2'd0, 5'd0);
    issue(KIND_TEXT, 8'h00, 2'd0, 5'd0);
    issue(KIND_TEXT, 8'hFF, 2'd0, 5'd0);
    // The row is full now, so this text is dropped and nothing is sent.
    issue(KIND_TEXT, 8'h41, 2'd0, 5'd0);
    // Every row offset, including a column past the end of the display.
    issue(KIND_SETPOS, 8'h00, 2'd1, 5'd31);
    issue(KIND_SETPOS, 8'h00, 2'd2, 5'd5);
    issue(KIND_SETPOS, 8'h00, 2'd3, 5'd19);
    // Every other kind of request is turned away while a command is running, and
    // an unused kind in the middle does not count as a tick.
    send_item(KIND_COMMAND, 8'h3C, 2'd0, 5'd0);
    send_item(KIND_TEXT, 8'h42, 2'd0, 5'd0);
    send_item(KIND_SETPOS, 8'h00, 2'd1, 5'd1);
    send_item(KIND_INIT, 8'h00, 2'd0, 5'd0);
    send_item(KIND_CLEAR, 8'h00, 2'd0, 5'd0);
    send_item(KIND_SPARE_B, 8'h00, 2'd0, 5'd0);
    run_ticks(run_length(KIND_COMMAND));
    issue(KIND_CLEAR, 8'h00, 2'd0, 5'd0);

    // Lowest register values: a zero settle acts as one tick, zero extra
    // waits are skipped, and a zero column limit drops all text. The write
    // to an index past the last register must leave everything alone.
    drain_results();
    write_reg(CFG_UNUSED, 13'h1FFF);
    program_timing(0, 0, 0, 0, 0);
    issue(KIND_INIT, 8'h00, 2'd0, 5'd0);
    issue(KIND_TEXT, 8'h55, 2'd0, 5'd0);
    issue(KIND_CLEAR, 8'h00, 2'd0, 5'd0);
    issue(KIND_COMMAND, 8'hC3, 2'd0, 5'd0);

    // Top values in the wait and column registers with a short settle time;
    // the last column of a 31-column row takes one more character and then
    // drops the next.
    drain_results();
    program_timing(2, 8191, 8191, 1023, 31);
    issue(KIND_SETPOS, 8'h00, 2'd3, 5'd30);
    issue(KIND_TEXT, 8'h80, 2'd0, 5'd0);
    issue(KIND_TEXT, 8'h7F, 2'd0, 5'd0);

    // Random phases. Each one starts from an empty pipeline, so the sender
    // holds off until all results are back before the timing changes.
    rand_goal = sent_items + RANDOM_ITEMS;
    while (sent_items < rand_goal) begin
      drain_results();
      random_timing();
      repeat ($urandom_range(3, 10)) random_sequence();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_char_lcd_four_bit_sequencer: done, clean");
    end else begin
      $display("tb_char_lcd_four_bit_sequencer: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/clsq_pkg.sv
rtl/clsq_front.sv
rtl/clsq_back.sv
rtl/char_lcd_four_bit_sequencer.sv
sim/clsq_checker.sv
sim/tb_char_lcd_four_bit_sequencer.sv
